### rtl/core/pllcw_pkg.sv
// ---------------------------------------------------------------------------
// pllcw_pkg: shared types and constants for the pll channel word calculator
// band thresholds, dividers, division cell payload
// ---------------------------------------------------------------------------
package pllcw_pkg;
	localparam int unsigned REF_W = 26;
	localparam int unsigned FREQ_W = 32;
	localparam int unsigned FRAC_W = 19;
	localparam int unsigned PFD_W = 27;
	localparam int unsigned DIVD_W = FREQ_W + FRAC_W;   // 51 quotient bits
	localparam logic [REF_W-1:0] REF_RESET = 26'd26000000;
	localparam logic [3:0] SYNTH_SELECT = 4'd8;

	typedef struct packed {
		logic [PFD_W:0]    rem;      // partial remainder
		logic [DIVD_W-1:0] dvd;      // dividend bits, shifted out msb first
		logic [DIVD_W-1:0] quo;      // quotient bits, shifted in lsb
		logic [PFD_W-1:0]  pfd;
		logic [2:0]        band;
		logic [4:0]        divider;
	} pllcw_cell_t;

	function automatic logic [2:0] band_of(input logic [FREQ_W-1:0] f);
		logic [2:0] b;
		b = 3'd0;
		if (f < 32'd705000000) b = 3'd1;
		if (f < 32'd470000000) b = 3'd2;
		if (f < 32'd353000000) b = 3'd3;
		if (f < 32'd235000000) b = 3'd4;
		if (f < 32'd177000000) b = 3'd5;
		return b;
	endfunction

	function automatic logic [4:0] div_of(input logic [2:0] b);
		logic [4:0] d;
		case (b)
			3'd0: d = 5'd4;
			3'd1: d = 5'd6;
			3'd2: d = 5'd8;
			3'd3: d = 5'd12;
			3'd4: d = 5'd16;
			default: d = 5'd24;
		endcase
		return d;
	endfunction
endpackage

### rtl/core/pllcw_pfd.sv
// ---------------------------------------------------------------------------
// pllcw_pfd: phase detector rate
// 2*ref / divider by reciprocal multiply and one-step correction
// ---------------------------------------------------------------------------
module pllcw_pfd import pllcw_pkg::*; (
	input  logic [REF_W-1:0] reference_hz,
	input  logic [4:0]       divider,
	output logic [PFD_W-1:0] pfd
);
	// 2*ref = ref << 1; divider = {4,6,8,12,16,24} = 2^k * {1,3}
	logic [REF_W:0]  twice;
	logic [REF_W:0]  shifted;
	logic [REF_W+30:0] prod;
	logic [REF_W:0]  est;
	logic [REF_W+2:0] back;
	logic            three;
	always_comb begin
		twice = {reference_hz, 1'b0};
		case (divider)
			5'd4, 5'd12: shifted = twice >> 2;
			5'd8, 5'd24: shifted = twice >> 3;
			5'd16:       shifted = twice >> 4;
			default:     shifted = twice >> 1;
		endcase
		three = (divider == 5'd6) || (divider == 5'd12) || (divider == 5'd24);
		// x/3 ~ x*0x15555555 >> 30, at most one low, then correct once
		prod = {30'd0, shifted} * {27'd0, 30'h1555_5555};
		est = prod[REF_W+30:30];
		back = {2'b00, est} + {1'b0, est, 1'b0};
		if ({2'b00, shifted} - back >= 29'd3) est = est + 1'b1;
		pfd = three ? est : shifted;
	end
endmodule

### rtl/core/pllcw_cell.sv
// ---------------------------------------------------------------------------
// pllcw_cell: one restoring division step
// shifts one dividend bit into the remainder, subtracts pfd when it fits
// ---------------------------------------------------------------------------
module pllcw_cell import pllcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vin,
	input  pllcw_cell_t din,
	output logic        vout,
	output pllcw_cell_t dout
);
	pllcw_cell_t nx;
	logic [PFD_W+1:0] sh;
	logic [PFD_W+1:0] diff;
	always_comb begin
		nx = din;
		sh = {din.rem, din.dvd[DIVD_W-1]};
		diff = sh - {2'b00, din.pfd};
		nx.dvd = {din.dvd[DIVD_W-2:0], 1'b0};
		if (!diff[PFD_W+1]) begin
			nx.rem = diff[PFD_W:0];
			nx.quo = {din.quo[DIVD_W-2:0], 1'b1};
		end else begin
			nx.rem = sh[PFD_W:0];
			nx.quo = {din.quo[DIVD_W-2:0], 1'b0};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) dout <= nx;
	end
endmodule

### rtl/core/pll_channel_word_calc_unit.sv
// ---------------------------------------------------------------------------
// pll_channel_word_calc_unit: fractional-n channel word calculator
// stages: input reg, 51 division cells, output reg
// throughput: one word per cycle while not stalled, set by the chain of 51 division cells
// whole chain stalls together when the output word is not taken
// reset: reference_hz returns to 26000000, all valid flags clear
// ---------------------------------------------------------------------------
module pll_channel_word_calc_unit import pllcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [REF_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FREQ_W-1:0] carrier_hz,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        band_code,
	output logic [7:0]        integer_word,
	output logic [19:0]       fraction_word,
	output logic [4:0]        divider_used,
	output logic              range_error
);
	logic [REF_W-1:0] ref_q;
	logic             en;
	logic [2:0]       band_in;
	logic [4:0]       div_in;
	logic [PFD_W-1:0] pfd_in;
	pllcw_cell_t      head_s1;
	logic             v_s1;
	logic             vc [DIVD_W+1];
	pllcw_cell_t      dc [DIVD_W+1];
	logic [FREQ_W-1:0] q;
	logic [FRAC_W-1:0] fr;
	pllcw_cell_t      tail;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ref_q <= REF_RESET;
		else if (cfg_we) ref_q <= cfg_wdata;
	end

	// whole chain advances unless the output word is held
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: band and pfd
	assign band_in = band_of(carrier_hz);
	assign div_in = div_of(band_in);
	pllcw_pfd u_pfd (.reference_hz(ref_q), .divider(div_in), .pfd(pfd_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			head_s1.rem <= '0;
			head_s1.dvd <= {carrier_hz, {FRAC_W{1'b0}}};
			head_s1.quo <= '0;
			head_s1.pfd <= pfd_in;
			head_s1.band <= band_in;
			head_s1.divider <= div_in;
		end
	end

	assign vc[0] = v_s1;
	assign dc[0] = head_s1;
	// row of division cells, one quotient bit each
	for (genvar g = 0; g < DIVD_W; g++) begin : g_cell
		pllcw_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en),
			.vin(vc[g]), .din(dc[g]), .vout(vc[g+1]), .dout(dc[g+1]));
	end

	// quotient of (carrier << 19)/pfd: high bits are q, low bits the fraction
	assign tail = dc[DIVD_W];
	assign q = tail.quo[DIVD_W-1:FRAC_W];
	assign fr = tail.quo[FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vc[DIVD_W];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			band_code <= {1'b0, tail.band} + SYNTH_SELECT;
			divider_used <= tail.divider;
			if (tail.pfd == '0) begin
				// zero detector rate
				integer_word <= '0;
				fraction_word <= '0;
				range_error <= 1'b1;
			end else begin
				integer_word <= q[7:0] - 8'd1;
				fraction_word <= {1'b1, fr};
				range_error <= (q == '0) || (q > 32'd256);
			end
		end
	end
endmodule

### tb/pll_channel_word_calc_unit_tb.sv
// ---------------------------------------------------------------------------
// pll_channel_word_calc_unit_tb: self-checking bench for the channel word calculator
// drives carrier words through the pipeline, predicts band, divider, integer
// and fraction words per word, and checks every output word in order
// ---------------------------------------------------------------------------
module pll_channel_word_calc_unit_tb;
	import pllcw_pkg::*;

	typedef struct packed {
		logic [3:0]  band;
		logic [7:0]  nword;
		logic [19:0] mword;
		logic [4:0]  div;
		logic        err;
	} chan_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [REF_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [FREQ_W-1:0] carrier_hz = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [3:0]        band_code;
	logic [7:0]        integer_word;
	logic [19:0]       fraction_word;
	logic [4:0]        divider_used;
	logic              range_error;

	// predictor copy of the reference register
	logic [REF_W-1:0] ref_hz = REF_RESET;
	chan_word_t       pending_words[$];
	int               mismatch_cnt = 0;
	int               words_seen = 0;
	int               hold_cycles = 0;
	int               hold_req = 0;
	int               hold_ack = 0;
	bit               stim_done = 1'b0;

	// latency of the pipeline plus margin
	localparam int DRAIN_CYCLES = 80;

	always #5 clk = ~clk;

	pll_channel_word_calc_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.carrier_hz   (carrier_hz),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.band_code    (band_code),
		.integer_word (integer_word),
		.fraction_word(fraction_word),
		.divider_used (divider_used),
		.range_error  (range_error)
	);

	// expected channel word for one carrier under the current reference
	function automatic chan_word_t calc_chan_word(input logic [31:0] f, input logic [25:0] rf);
		chan_word_t w;
		logic [2:0]  b;
		logic [4:0]  d;
		logic [31:0] pfd, q, r, n;
		logic [63:0] frac;
		b = 3'd0;
		if (f < 32'd705000000) b = 3'd1;
		if (f < 32'd470000000) b = 3'd2;
		if (f < 32'd353000000) b = 3'd3;
		if (f < 32'd235000000) b = 3'd4;
		if (f < 32'd177000000) b = 3'd5;
		case (b)
			3'd0: d = 5'd4;
			3'd1: d = 5'd6;
			3'd2: d = 5'd8;
			3'd3: d = 5'd12;
			3'd4: d = 5'd16;
			default: d = 5'd24;
		endcase
		w.band = 4'(b) + 4'd8;
		w.div = d;
		pfd = (32'(rf) * 2) / 32'(d);
		if (pfd == 0) begin
			w.nword = '0;
			w.mword = '0;
			w.err = 1'b1;
		end else begin
			q = f / pfd;
			r = f % pfd;
			n = q - 1;
			frac = (64'(r) << 19) / 64'(pfd);
			w.nword = n[7:0];
			w.mword = 20'((64'd1 << 19) + frac);
			w.err = (q == 0) || (q > 256);
		end
		return w;
	endfunction

	// send one carrier word; burst/gap idling between words
	int burst_left = 0;
	task automatic send_carrier(input logic [31:0] f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		carrier_hz <= f;
		pending_words.push_back(calc_chan_word(f, ref_hz));
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// registers only change with the pipeline empty
	task automatic write_ref(input logic [25:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		ref_hz = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_carrier();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(177000000, 1100000000);
			2: return $urandom_range(0, 2000000);
			default: return $urandom_range(100000000, 1050000000);
		endcase
	endfunction

	// band edges, extremes, zero quotient, oversized quotient
	task automatic test_directed();
		logic [31:0] edges[10] = '{705000000, 704999999, 470000000, 469999999,
			353000000, 352999999, 235000000, 234999999, 177000000, 176999999};
		foreach (edges[i]) send_carrier(edges[i]);
		send_carrier(32'd0);
		send_carrier(32'd1);
		send_carrier(32'hFFFF_FFFF);
		send_carrier(32'hAAAA_AAAA);
		send_carrier(32'h5555_5555);
		send_carrier(32'd868000000);
		send_carrier(32'd433920000);
		send_carrier(32'd2166666);   // pfd exactly with 26 mhz, quotient one
		send_carrier(32'd4333333);
	endtask

	task automatic test_reference_sweep();
		logic [25:0] refs[6] = '{26'd10000000, 26'd40000000, 26'h3FF_FFFF, 26'd5,
			26'd11, 26'd0};
		foreach (refs[i]) begin
			write_ref(refs[i]);
			repeat (15) send_carrier(rand_carrier());
			send_carrier(32'd0);
			send_carrier(32'hFFFF_FFFF);
		end
		write_ref(26'h155_5555);
		repeat (10) send_carrier(rand_carrier());
	endtask

	task automatic test_random_stream();
		write_ref(26'($urandom_range(10000000, 40000000)));
		repeat (400) send_carrier(rand_carrier());
		write_ref(REF_RESET);
		repeat (350) send_carrier(rand_carrier());
	endtask

	// long receiver hold so the chain fills and in_ready drops
	task automatic test_backpressure();
		wait_drained();
		hold_req++;
		repeat (90) send_carrier(rand_carrier());
		wait_drained();
	endtask

	// receiver stall pattern; a hold request forces a long stretch
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= 150;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			case (($urandom_range(0, 99) + words_seen / 64) % 4)
				0: out_ready <= ($urandom_range(0, 3) != 0);
				1: out_ready <= 1'b1;
				2: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
			endcase
		end
	end

	// output checker, compares against oldest expected word
	always @(posedge clk) begin
		chan_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			words_seen <= words_seen + 1;
			if (pending_words.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected output word at %0t", $time);
			end else begin
				exp_w = pending_words.pop_front();
				if (exp_w.band !== band_code || exp_w.nword !== integer_word ||
						exp_w.mword !== fraction_word || exp_w.div !== divider_used ||
						exp_w.err !== range_error) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("mismatch at %0t exp band %0d n %0d m %0d div %0d err %0b",
							$time, exp_w.band, exp_w.nword, exp_w.mword, exp_w.div,
							exp_w.err);
						$display("  got band %0d n %0d m %0d div %0d err %0b",
							band_code, integer_word, fraction_word,
							divider_used, range_error);
					end
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reference_sweep();
		test_backpressure();
		test_random_stream();
		wait_drained();
		if (mismatch_cnt == 0 && pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
